// ----- hdl/min_filter_3x3_core_assert.svh -----
// ----------------------------------------------------------------------------
// min_filter_3x3_core_assert.svh
// assertion macros shared by the min filter rtl
// ----------------------------------------------------------------------------
`ifndef MIN_FILTER_3X3_CORE_ASSERT_SVH
`define MIN_FILTER_3X3_CORE_ASSERT_SVH

// same-cycle implication
`define MF3_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define MF3_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/mf3_pkg.sv -----
// ----------------------------------------------------------------------------
// mf3_pkg
// shared types, constants and helpers of the 3x3 minimum filter
// ----------------------------------------------------------------------------
`default_nettype none

package mf3_pkg;

   localparam int PIX_W        = 8;
   localparam int ROW_W        = 11;
   localparam int CFG_W        = 12;
   localparam int CSR_IDX_W    = 2;
   localparam int MIN_DIM      = 3;
   localparam int MAX_HEIGHT   = 2048;
   localparam int MAX_WIDTH_DEF = 2048;
   localparam int CHANNELS_DEF = 3;
   localparam int NUM_LANES    = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH  = 2'd0,
      CSR_IMAGE_HEIGHT = 2'd1,
      CSR_COLOUR_MODE  = 2'd2
   } csr_index_type;

   // control from the top to each lane
   typedef struct packed {
      logic shift;
      logic load;
   } lane_ctrl_type;

   typedef struct packed {
      logic [PIX_W-1:0] min_a;
      logic [PIX_W-1:0] min_b;
      logic [PIX_W-1:0] min_c;
      logic             last_result;
   } rsp_payload_type;

   function automatic logic [PIX_W-1:0] min3(input logic [PIX_W-1:0] a,
                                             input logic [PIX_W-1:0] b,
                                             input logic [PIX_W-1:0] c);
      logic [PIX_W-1:0] ab;
      ab = (a < b) ? a : b;
      return (ab < c) ? ab : c;
   endfunction

endpackage

`default_nettype wire

// ----- hdl/mf3_if.sv -----
// ----------------------------------------------------------------------------
// mf3_if
// request and response stream interfaces of the 3x3 minimum filter
// ----------------------------------------------------------------------------
`default_nettype none

interface mf3_req_if import mf3_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] chan_a;
   logic [PIX_W-1:0] chan_b;
   logic [PIX_W-1:0] chan_c;

   modport source (output valid, output chan_a, output chan_b, output chan_c,
                   input ready);
   modport sink   (input valid, input chan_a, input chan_b, input chan_c,
                   output ready);
endinterface

interface mf3_rsp_if import mf3_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] min_a;
   logic [PIX_W-1:0] min_b;
   logic [PIX_W-1:0] min_c;
   logic             last_result;

   modport source (output valid, output min_a, output min_b, output min_c,
                   output last_result, input ready);
   modport sink   (input valid, input min_a, input min_b, input min_c,
                   input last_result, output ready);
endinterface

`default_nettype wire

// ----- hdl/mf3_ram.sv -----
// ----------------------------------------------------------------------------
// mf3_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module mf3_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 2048
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- hdl/mf3_lane.sv -----
// ----------------------------------------------------------------------------
// mf3_lane
// one channel: 3x3 window of samples and its registered minimum
// ----------------------------------------------------------------------------
`default_nettype none

module mf3_lane import mf3_pkg::*; (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire lane_ctrl_type             ctrl,
   input  wire logic [2:0][PIX_W-1:0]     col_data,   // [0] top, [2] bottom
   output      logic [PIX_W-1:0]          lane_min
);

   logic [2:0][2:0][PIX_W-1:0] win_ff;   // [row][col], col 2 newest
   logic [PIX_W-1:0]           min_ff;
   logic [PIX_W-1:0]           min_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= '0;
      end else if (ctrl.shift) begin
         for (int r = 0; r < 3; r++) begin
            win_ff[r][0] <= win_ff[r][1];
            win_ff[r][1] <= win_ff[r][2];
            win_ff[r][2] <= col_data[r];
         end
      end
   end

   // row minimums, then the minimum of the rows
   assign min_in = min3(min3(win_ff[0][0], win_ff[0][1], win_ff[0][2]),
                        min3(win_ff[1][0], win_ff[1][1], win_ff[1][2]),
                        min3(win_ff[2][0], win_ff[2][1], win_ff[2][2]));

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         min_ff <= min_in;
      end
   end

   assign lane_min = min_ff;

endmodule

`default_nettype wire

// ----- hdl/min_filter_3x3_core.sv -----
// ----------------------------------------------------------------------------
// min_filter_3x3_core
// 3x3 minimum filter over a raster pixel stream, grey or three colour lanes
// ----------------------------------------------------------------------------
// a result passes the line store read, window shift, lane minimum and output queue
// throughput: one request per cycle, sustained while the response side takes
//   one result per cycle; set by the one read and one write per line store
// reset: synchronous, clears counters, pipeline valids, window and output queue
// line stores are not cleared; no clearing pass, requests accepted right away
// ----------------------------------------------------------------------------
`default_nettype none

`include "min_filter_3x3_core_assert.svh"

module min_filter_3x3_core import mf3_pkg::*; #(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF,
   parameter int CHANNELS  = CHANNELS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   mf3_req_if.sink                   req_bus,
   mf3_rsp_if.source                 rsp_bus,
   input  wire logic                 csr_write_en,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CFG_W-1:0]     csr_write_data
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int DW = CHANNELS * PIX_W;

   // configuration registers
   logic [CFG_W-1:0] img_width_ff;
   logic [CFG_W-1:0] img_height_ff;
   logic             colour_mode_ff;
   logic             csr_hit;

   // pixel position of the next request
   logic [CW-1:0]    col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [CW-1:0]    width_last;
   logic [ROW_W-1:0] height_last;

   // pipeline
   logic             en;
   logic             accept;
   logic [DW-1:0]    pix;
   logic             s1_valid_ff;
   logic             s1_res_ff;
   logic             s1_last_ff;
   logic [CW-1:0]    s1_col_ff;
   logic [DW-1:0]    s1_pix_ff;
   logic             s2_valid_ff;
   logic             s2_last_ff;
   logic             s3_valid_ff;
   logic             s3_last_ff;
   logic [DW-1:0]    upper_q;
   logic [DW-1:0]    lower_q;
   lane_ctrl_type    lane_ctrl;
   logic [NUM_LANES-1:0][PIX_W-1:0] lane_min;
   logic [NUM_LANES-1:0][PIX_W-1:0] req_chans;

   // output queue, two entries
   rsp_payload_type  q_data_ff [2];
   logic             q_wr_ptr_ff;
   logic             q_rd_ptr_ff;
   logic [1:0]       q_count_ff, q_count_in;
   logic             push;
   logic             pop;

   // ------------------------------------------------------------------------
   // configuration port, any valid write restarts the image
   // ------------------------------------------------------------------------
   always_comb begin
      case (csr_index_type'(csr_index))
         CSR_IMAGE_WIDTH:  csr_hit = csr_write_en;
         CSR_IMAGE_HEIGHT: csr_hit = csr_write_en;
         CSR_COLOUR_MODE:  csr_hit = csr_write_en;
         default:          csr_hit = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         img_width_ff   <= CFG_W'(MIN_DIM);
         img_height_ff  <= CFG_W'(MIN_DIM);
         colour_mode_ff <= 1'b0;
      end else if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_IMAGE_WIDTH:  img_width_ff   <= csr_write_data;
            CSR_IMAGE_HEIGHT: img_height_ff  <= csr_write_data;
            CSR_COLOUR_MODE:  colour_mode_ff <= csr_write_data[0];
            default:          ;
         endcase
      end
   end

   // saturated image size, as last index
   always_comb begin
      if (img_width_ff < CFG_W'(MIN_DIM)) begin
         width_last = CW'(MIN_DIM - 1);
      end else if (32'(img_width_ff) > MAX_WIDTH) begin
         width_last = CW'(MAX_WIDTH - 1);
      end else begin
         width_last = CW'(32'(img_width_ff) - 32'd1);
      end
      if (img_height_ff < CFG_W'(MIN_DIM)) begin
         height_last = ROW_W'(MIN_DIM - 1);
      end else if (32'(img_height_ff) > MAX_HEIGHT) begin
         height_last = ROW_W'(MAX_HEIGHT - 1);
      end else begin
         height_last = ROW_W'(32'(img_height_ff) - 32'd1);
      end
   end

   // ------------------------------------------------------------------------
   // request side: the pipeline moves whenever the queue has room
   // ------------------------------------------------------------------------
   assign en            = (q_count_ff != 2'd2);
   assign req_bus.ready = en;
   assign accept        = req_bus.valid && en;

   // pack the channels; extra channels read as zero in grey mode
   assign req_chans = {req_bus.chan_c, req_bus.chan_b, req_bus.chan_a};

   always_comb begin
      pix = '0;
      for (int k = 0; k < CHANNELS; k++) begin
         if (k == 0 || (colour_mode_ff && CHANNELS == 3)) begin
            pix[k*PIX_W +: PIX_W] = req_chans[k];
         end
      end
   end

   // raster position, wraps at the end of a row and of the image
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (csr_hit) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (col_ff == width_last) begin
            col_in = '0;
            row_in = (row_ff == height_last) ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // ------------------------------------------------------------------------
   // stage 1: line store read in flight, request pixel held beside it
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         // interior pixel centered one row up and one column left
         s1_res_ff  <= (row_ff >= ROW_W'(2)) && (col_ff >= CW'(2));
         s1_last_ff <= (row_ff == height_last) && (col_ff == width_last);
         s1_col_ff  <= col_ff;
         s1_pix_ff  <= pix;
      end
   end

   // upper store holds row r-2, lower store row r-1; both read at the
   // request column and written back at the same column when stage 1 moves
   mf3_ram #(
      .WIDTH (DW),
      .DEPTH (MAX_WIDTH)
   ) u_line_upper (
      .clock   (clock),
      .wr_en   (en && s1_valid_ff),
      .wr_addr (s1_col_ff),
      .wr_data (lower_q),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (upper_q)
   );

   mf3_ram #(
      .WIDTH (DW),
      .DEPTH (MAX_WIDTH)
   ) u_line_lower (
      .clock   (clock),
      .wr_en   (en && s1_valid_ff),
      .wr_addr (s1_col_ff),
      .wr_data (s1_pix_ff),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (lower_q)
   );

   // ------------------------------------------------------------------------
   // stage 2: window shift in each lane; stage 3: lane minimums
   // ------------------------------------------------------------------------
   assign lane_ctrl.shift = en && s1_valid_ff;
   assign lane_ctrl.load  = en;

   for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
      if (k < CHANNELS) begin : g_on
         mf3_lane u_lane (
            .clock    (clock),
            .reset    (reset),
            .ctrl     (lane_ctrl),
            .col_data ({s1_pix_ff[k*PIX_W +: PIX_W],
                        lower_q[k*PIX_W +: PIX_W],
                        upper_q[k*PIX_W +: PIX_W]}),
            .lane_min (lane_min[k])
         );
      end else begin : g_off
         assign lane_min[k] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (en) begin
         s2_valid_ff <= s1_valid_ff && s1_res_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_last_ff <= s1_last_ff;
         s3_last_ff <= s2_last_ff;
      end
   end

   // ------------------------------------------------------------------------
   // merge the lanes into one result and queue it for the response side
   // ------------------------------------------------------------------------
   assign push = en && s3_valid_ff;
   assign pop  = rsp_bus.valid && rsp_bus.ready;

   always_ff @(posedge clock) begin
      if (push) begin
         q_data_ff[q_wr_ptr_ff] <= '{min_a:       lane_min[0],
                                     min_b:       lane_min[1],
                                     min_c:       lane_min[2],
                                     last_result: s3_last_ff};
      end
   end

   always_comb begin
      case ({push, pop})
         2'b10:   q_count_in = q_count_ff + 2'd1;
         2'b01:   q_count_in = q_count_ff - 2'd1;
         default: q_count_in = q_count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_count_ff  <= '0;
         q_wr_ptr_ff <= 1'b0;
         q_rd_ptr_ff <= 1'b0;
      end else begin
         q_count_ff <= q_count_in;
         if (push) begin
            q_wr_ptr_ff <= !q_wr_ptr_ff;
         end
         if (pop) begin
            q_rd_ptr_ff <= !q_rd_ptr_ff;
         end
      end
   end

   assign rsp_bus.valid       = (q_count_ff != 2'd0);
   assign rsp_bus.min_a       = q_data_ff[q_rd_ptr_ff].min_a;
   assign rsp_bus.min_b       = q_data_ff[q_rd_ptr_ff].min_b;
   assign rsp_bus.min_c       = q_data_ff[q_rd_ptr_ff].min_c;
   assign rsp_bus.last_result = q_data_ff[q_rd_ptr_ff].last_result;

   // ------------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------------
   `MF3_ASSERT_IMP(a_q_bound, clock, reset, 1'b1, q_count_ff != 2'd3,
                   "output queue over two entries")
   `MF3_ASSERT_NXT(a_q_drain, clock, reset, pop && !push,
                   q_count_ff == $past(q_count_ff) - 2'd1,
                   "output queue count did not drop on a pop")
   `MF3_ASSERT_NXT(a_csr_restart, clock, reset, csr_hit,
                   col_ff == '0 && row_ff == '0,
                   "register write did not restart the image")
   `MF3_ASSERT_NXT(a_row_wrap, clock, reset,
                   accept && !csr_hit && col_ff == width_last,
                   col_ff == '0, "column did not wrap at row end")
   `MF3_ASSERT_NXT(a_stage_move, clock, reset, en && s2_valid_ff,
                   s3_valid_ff, "result lost between window and lane minimum")

endmodule

`default_nettype wire
